// ===== rtl/bmf_pkg.sv =====
// Shared constants and types for the 7x7 box mean filter.
`timescale 1ns / 1ps

package bmf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int RADIUS     = 3;
    localparam int LINES      = 2 * RADIUS;
    localparam int WIN        = 2 * RADIUS + 1;
    localparam int AREA       = WIN * WIN;

    localparam int PIX_W      = 8;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 12;
    localparam int LANE_W     = 3;
    localparam int CSUM_W     = 11;
    localparam int WSUM_W     = 14;
    localparam int MEAN_W     = 8;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int LS_W       = LINES * PIX_W;

    // floor(s / 49) == (s * 10700) >> 19 for every s below 2^14; max sum 12495
    localparam int RECIP_W     = 14;
    localparam int RECIP       = 10700;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = WSUM_W + RECIP_W;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd512;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd512;
    localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = 11'd7;
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = 11'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = 13'd7;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = 13'd4096;

    // pixel in flight between the line store read and its write-back
    typedef struct packed {
        logic [PIX_W-1:0]  px;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [LANE_W-1:0] lane;
        logic              full_rows;
        logic              emit;
        logic              frame_end;
    } pix_stage_t;

    // interior window waiting for the divide
    typedef struct packed {
        logic [ROW_W-1:0]  centre_row;
        logic [COL_W-1:0]  centre_col;
        logic [WSUM_W-1:0] sum;
        logic              last;
    } win_stage_t;

endpackage

// ===== rtl/bmf_pixel_if.sv =====
// Pixel request channel.
`timescale 1ns / 1ps

interface bmf_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [bmf_pkg::PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// ===== rtl/bmf_result_if.sv =====
// Filtered result channel.
`timescale 1ns / 1ps

interface bmf_result_if;
    logic                       valid;
    logic                       ready;
    logic [bmf_pkg::ROW_W-1:0]  centre_row;
    logic [bmf_pkg::COL_W-1:0]  centre_col;
    logic [bmf_pkg::MEAN_W-1:0] mean;
    logic                       last_of_frame;

    modport source (output valid, output centre_row, output centre_col, output mean,
                    output last_of_frame, input ready);
    modport sink   (input valid, input centre_row, input centre_col, input mean,
                    input last_of_frame, output ready);
endinterface

// ===== rtl/bmf_cfg_if.sv =====
// Configuration write channel.
`timescale 1ns / 1ps

interface bmf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bmf_pkg::CFG_IDX_W-1:0]  index;
    logic [bmf_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/box_mean_filter_7x7.sv =====
// Top level of the 7x7 box mean filter.
`timescale 1ns / 1ps
// Usage:
//   cfg     : register writes, index 0 = image_width, 1 = image_height. Always ready;
//             write only while no pixel is in flight. Sizes saturate (width mod 2048).
//   pixels  : 8-bit greyscale pixels in raster order, one request per pixel.
//   results : one request per window centre at least three pixels from every border,
//             carrying centre row/column, the truncated 7x7 mean and a last-of-frame
//             mark on the final interior result. Border pixels give no result.
// Throughput: one pixel per clock unless results stalls. The line store is a 1024 x 48
//   RAM that holds the six previous rows of a column in one word; each pixel reads its
//   column word in the accept cycle and writes it back from stage 1, with its own lane
//   replaced. Successive pixels touch different columns, so no forwarding is needed.
// Datapath: a pixel's result is formed by the line store read, the column/window sum
//   and the divide by 49 into the output register, in that order.
// Reset: counters, column window and window sum clear; width and height return to
//   512. The line store is not cleared and needs no clearing pass.
// Stall: while results is stalled the output register holds; the two stages ahead
//   keep filling, and pixels that give no result keep flowing through.
module box_mean_filter_7x7 (
    input  logic                 clk,
    input  logic                 rst_n,
    bmf_cfg_if.sink              cfg,
    bmf_pixel_if.sink            pixels,
    bmf_result_if.source         results
);

    // ---------------- configuration
    logic [bmf_pkg::WIDTH_W-1:0]  width_reg;
    logic [bmf_pkg::HEIGHT_W-1:0] height_reg;
    logic [bmf_pkg::WIDTH_W-1:0]  eff_w;
    logic [bmf_pkg::HEIGHT_W-1:0] eff_h;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bmf_pkg::WIDTH_RESET;
            height_reg <= bmf_pkg::HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                bmf_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg.data[bmf_pkg::WIDTH_W-1:0];
                bmf_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg < bmf_pkg::WIDTH_MIN)
            eff_w = bmf_pkg::WIDTH_MIN;
        else if (width_reg > bmf_pkg::WIDTH_MAX)
            eff_w = bmf_pkg::WIDTH_MAX;
        else
            eff_w = width_reg;

        if (height_reg < bmf_pkg::HEIGHT_MIN)
            eff_h = bmf_pkg::HEIGHT_MIN;
        else if (height_reg > bmf_pkg::HEIGHT_MAX)
            eff_h = bmf_pkg::HEIGHT_MAX;
        else
            eff_h = height_reg;
    end

    // ---------------- pipeline handshake
    logic                  s1_valid_reg;
    bmf_pkg::pix_stage_t   s1_reg;
    logic                  s2_valid_reg;
    bmf_pkg::win_stage_t   s2_reg;
    logic                  out_valid_reg;

    logic out_free;
    logic s2_move;
    logic s2_free;
    logic s1_move;
    logic s1_free;
    logic accept;

    assign out_free     = !out_valid_reg || results.ready;
    assign s2_move      = s2_valid_reg && out_free;
    assign s2_free      = !s2_valid_reg || out_free;
    assign s1_move      = s1_valid_reg && (!s1_reg.emit || s2_free);
    assign s1_free      = !s1_valid_reg || s1_move;
    assign pixels.ready = s1_free;
    assign accept       = pixels.valid && s1_free;

    // ---------------- position counters
    logic [bmf_pkg::COL_W-1:0]  col_reg, col_next;
    logic [bmf_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [bmf_pkg::LANE_W-1:0] lane_reg, lane_next;
    logic                       row_end;
    logic                       frame_end;

    assign row_end   = ({1'b0, col_reg} + 11'd1) >= eff_w;
    assign frame_end = row_end && (({1'b0, row_reg} + 13'd1) >= eff_h);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        lane_next = lane_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                if (frame_end)
                begin
                    row_next  = '0;
                    lane_next = '0;
                end
                else
                begin
                    row_next  = row_reg + 12'd1;
                    lane_next = (lane_reg == 3'(bmf_pkg::LINES - 1)) ? '0 : lane_reg + 3'd1;
                end
            end
            else
            begin
                col_next = col_reg + 10'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            lane_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            lane_reg <= lane_next;
        end
    end

    // ---------------- stage 1: line store read, then write-back
    logic [bmf_pkg::LS_W-1:0] ls_rdata;
    logic [bmf_pkg::LS_W-1:0] ls_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_free)
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.px        <= pixels.pixel;
            s1_reg.col       <= col_reg;
            s1_reg.row       <= row_reg;
            s1_reg.lane      <= lane_reg;
            s1_reg.full_rows <= row_reg >= 12'(bmf_pkg::LINES);
            s1_reg.emit      <= (row_reg >= 12'(bmf_pkg::LINES))
                                && (col_reg >= 10'(bmf_pkg::LINES));
            s1_reg.frame_end <= frame_end;
        end
    end

    bmf_ram #(
        .WIDTH (bmf_pkg::LS_W),
        .DEPTH (bmf_pkg::MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (s1_move),
        .waddr (s1_reg.col),
        .wdata (ls_wdata),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ls_rdata)
    );

    // replace this row's lane; sum the column
    logic [bmf_pkg::CSUM_W-1:0] colsum;

    always_comb
    begin
        logic [bmf_pkg::CSUM_W-1:0] acc;
        acc = {3'b0, s1_reg.px};
        for (int i = 0; i < bmf_pkg::LINES; i++)
        begin
            ls_wdata[i*bmf_pkg::PIX_W +: bmf_pkg::PIX_W] =
                (s1_reg.lane == 3'(i)) ? s1_reg.px
                                       : ls_rdata[i*bmf_pkg::PIX_W +: bmf_pkg::PIX_W];
            acc = acc + {3'b0, ls_rdata[i*bmf_pkg::PIX_W +: bmf_pkg::PIX_W]};
        end
        colsum = s1_reg.full_rows ? acc : '0;
    end

    // ---------------- horizontal window
    logic [bmf_pkg::CSUM_W-1:0] win_reg  [bmf_pkg::WIN];
    logic [bmf_pkg::CSUM_W-1:0] win_next [bmf_pkg::WIN];
    logic [bmf_pkg::WSUM_W-1:0] wsum_reg, wsum_next;

    always_comb
    begin
        logic [bmf_pkg::WSUM_W:0] t;
        if (s1_reg.col == '0)
        begin
            for (int i = 0; i < bmf_pkg::WIN - 1; i++)
                win_next[i] = '0;
            t = {4'b0, colsum};
        end
        else
        begin
            for (int i = 0; i < bmf_pkg::WIN - 1; i++)
                win_next[i] = win_reg[i+1];
            t = {1'b0, wsum_reg} + {4'b0, colsum} - {4'b0, win_reg[0]};
        end
        win_next[bmf_pkg::WIN-1] = colsum;
        wsum_next = t[bmf_pkg::WSUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bmf_pkg::WIN; i++)
                win_reg[i] <= '0;
            wsum_reg <= '0;
        end
        else if (s1_move)
        begin
            for (int i = 0; i < bmf_pkg::WIN; i++)
                win_reg[i] <= win_next[i];
            wsum_reg <= wsum_next;
        end
    end

    // ---------------- stage 2: interior window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_free)
            s2_valid_reg <= s1_move && s1_reg.emit;
    end

    always_ff @(posedge clk)
    begin
        if (s2_free && s1_move && s1_reg.emit)
        begin
            s2_reg.centre_row <= s1_reg.row - 12'(bmf_pkg::RADIUS);
            s2_reg.centre_col <= s1_reg.col - 10'(bmf_pkg::RADIUS);
            s2_reg.sum        <= wsum_next;
            s2_reg.last       <= s1_reg.frame_end;
        end
    end

    // ---------------- output register: divide by 49 via reciprocal
    logic [bmf_pkg::PROD_W-1:0] prod;

    assign prod = {14'b0, s2_reg.sum} * bmf_pkg::PROD_W'(bmf_pkg::RECIP);

    logic [bmf_pkg::ROW_W-1:0]  out_row_reg;
    logic [bmf_pkg::COL_W-1:0]  out_col_reg;
    logic [bmf_pkg::MEAN_W-1:0] out_mean_reg;
    logic                       out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s2_move;
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            out_row_reg  <= s2_reg.centre_row;
            out_col_reg  <= s2_reg.centre_col;
            out_mean_reg <= prod[bmf_pkg::RECIP_SHIFT +: bmf_pkg::MEAN_W];
            out_last_reg <= s2_reg.last;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.centre_row    = out_row_reg;
    assign results.centre_col    = out_col_reg;
    assign results.mean          = out_mean_reg;
    assign results.last_of_frame = out_last_reg;

endmodule

// ===== rtl/bmf_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module bmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== bench/box_mean_filter_7x7_tb.sv =====
// Self-checking bench for the 7x7 box mean filter: directed frames, then random frames.
`timescale 1ns / 1ps

module box_mean_filter_7x7_tb;

    import bmf_pkg::*;

    localparam int PIPE_DRAIN  = 4;      // pipeline depth plus margin
    localparam int PHASE_ITEMS = 100;
    localparam int DRAIN_LIMIT = 50000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum logic [1:0] {FILL_CONST, FILL_RAMP, FILL_RANDOM, FILL_EXTREME} fill_t;

    typedef struct packed {
        logic [ROW_W-1:0]  centre_row;
        logic [COL_W-1:0]  centre_col;
        logic [MEAN_W-1:0] mean;
        logic              last;
    } window_mean_t;

    typedef struct packed {
        bit                    do_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        int unsigned           npix;
        fill_t                 fill;
        logic [PIX_W-1:0]      val;
        bit                    typed;    // mean known up front: uniform frame
    } frame_step_t;

    frame_step_t directed_frames [19] = '{
        // defaults after reset: one 512-wide row, then narrow to 7 and cut the frame at row 7
        '{1'b0, REG_IMAGE_WIDTH,  13'd0,    512,      FILL_CONST,  8'd255, 1'b1},
        '{1'b1, REG_IMAGE_WIDTH,  13'd7,    42,       FILL_CONST,  8'd255, 1'b1},
        '{1'b1, REG_IMAGE_HEIGHT, 13'd7,    7,        FILL_CONST,  8'd255, 1'b1},
        '{1'b1, REG_IMAGE_WIDTH,  13'd0,    0,        FILL_CONST,  8'd0,   1'b0},
        '{1'b1, REG_IMAGE_HEIGHT, 13'd0,    49,       FILL_CONST,  8'd0,   1'b1},
        '{1'b0, REG_IMAGE_WIDTH,  13'd0,    49,       FILL_CONST,  8'd255, 1'b1},
        '{1'b0, REG_IMAGE_WIDTH,  13'd0,    49,       FILL_RAMP,   8'd0,   1'b0},
        '{1'b1, REG_SPARE_2,      13'h1FFF, 0,        FILL_CONST,  8'd0,   1'b0},
        '{1'b1, REG_SPARE_3,      13'h0AAA, 49,       FILL_RANDOM, 8'd0,   1'b0},
        '{1'b1, REG_IMAGE_WIDTH,  13'h0807, 49,       FILL_CONST,  8'd77,  1'b1},
        // height saturates high: nine rows pass with no frame end, then cut at row 9
        '{1'b1, REG_IMAGE_HEIGHT, 13'h1FFF, 63,       FILL_RANDOM, 8'd0,   1'b0},
        '{1'b1, REG_IMAGE_HEIGHT, 13'd6,    7,        FILL_RANDOM, 8'd0,   1'b0},
        '{1'b1, REG_IMAGE_WIDTH,  13'd6,    49,       FILL_CONST,  8'd200, 1'b1},
        '{1'b1, REG_IMAGE_WIDTH,  13'd8,    0,        FILL_CONST,  8'd0,   1'b0},
        '{1'b1, REG_IMAGE_HEIGHT, 13'd9,    72,       FILL_RANDOM, 8'd0,   1'b0},
        // 20 x 12 frame, narrowed to 12 while at column 15, then cut to 8 rows at row 10
        '{1'b1, REG_IMAGE_WIDTH,  13'd20,   0,        FILL_CONST,  8'd0,   1'b0},
        '{1'b1, REG_IMAGE_HEIGHT, 13'd12,   195,      FILL_RANDOM, 8'd0,   1'b0},
        '{1'b1, REG_IMAGE_WIDTH,  13'd12,   1,        FILL_RANDOM, 8'd0,   1'b0},
        '{1'b1, REG_IMAGE_HEIGHT, 13'd8,    12,       FILL_RANDOM, 8'd0,   1'b0}
    };

    logic clk;
    logic rst_n;

    bmf_cfg_if    cfg_if ();
    bmf_pixel_if  pix_if ();
    bmf_result_if res_if ();

    box_mean_filter_7x7 dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_if),
        .pixels  (pix_if),
        .results (res_if)
    );

    // filter state mirrored on the bench side
    logic [PIX_W-1:0]    line_mem [LINES * MAX_WIDTH];
    logic [CSUM_W-1:0]   col_win [WIN];
    logic [WSUM_W-1:0]   win_sum;
    logic [ROW_W-1:0]    row_cnt;
    logic [COL_W-1:0]    col_cnt;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    window_mean_t pending_means [$];

    int mismatches;
    int pixels_sent;
    int means_seen;
    int frames_done;
    int reg_writes;
    int gap_pct;
    int stall_pct;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int unsigned eff_width();
        if (width_reg < WIN)
            return WIN;
        if (width_reg > MAX_WIDTH)
            return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg < WIN)
            return WIN;
        if (height_reg > MAX_HEIGHT)
            return MAX_HEIGHT;
        return height_reg;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_IMAGE_WIDTH:  width_reg = data[WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: height_reg = data[HEIGHT_W-1:0];
            default: ;
        endcase
    endfunction

    // Advances the mirrored filter by one pixel; returns 1 when a window mean comes out.
    function automatic bit filter_pixel(input logic [PIX_W-1:0] px, output window_mean_t r);
        int unsigned       w_eff;
        int unsigned       h_eff;
        int unsigned       col;
        int unsigned       row;
        logic [CSUM_W-1:0] colsum;
        logic [CSUM_W-1:0] dropped;
        bit                row_end;
        bit                frame_end;
        bit                hit;
        w_eff  = eff_width();
        h_eff  = eff_height();
        col    = col_cnt;
        row    = row_cnt;
        colsum = '0;
        r      = '0;
        hit    = 1'b0;
        if (row >= LINES)
        begin
            colsum = CSUM_W'(px);
            for (int k = 0; k < LINES; k++)
                colsum = colsum + CSUM_W'(line_mem[k * MAX_WIDTH + col]);
        end
        line_mem[(row % LINES) * MAX_WIDTH + col] = px;
        if (col == 0)
        begin
            for (int k = 0; k < WIN; k++)
                col_win[k] = '0;
            win_sum = '0;
        end
        dropped = col_win[0];
        for (int k = 0; k < WIN - 1; k++)
            col_win[k] = col_win[k + 1];
        col_win[WIN - 1] = colsum;
        win_sum = win_sum - WSUM_W'(dropped) + WSUM_W'(colsum);
        row_end   = (col + 1 >= w_eff);
        frame_end = row_end && (row + 1 >= h_eff);
        if (row >= LINES && col >= LINES)
        begin
            r.centre_row = ROW_W'(row - RADIUS);
            r.centre_col = COL_W'(col - RADIUS);
            r.mean       = MEAN_W'(win_sum / AREA);
            r.last       = frame_end;
            hit          = 1'b1;
        end
        if (row_end)
        begin
            col_cnt = '0;
            row_cnt = frame_end ? '0 : ROW_W'(row + 1);
            if (frame_end)
                frames_done++;
        end
        else
            col_cnt = COL_W'(col + 1);
        return hit;
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(fill_t fill, logic [PIX_W-1:0] level,
                                                    int unsigned n);
        case (fill)
            FILL_CONST:   return level;
            FILL_RAMP:    return PIX_W'(n);
            FILL_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
            default:      return PIX_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_size(int unsigned top);
        if ($urandom_range(7) == 0)
            return CFG_DATA_W'($urandom_range(WIN - 1));   // saturates up to the minimum
        return CFG_DATA_W'($urandom_range(top, WIN));
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // wait out every result still owed, then whatever pixels are left in the pipe
    task automatic settle();
        pix_if.valid <= 1'b0;
        while (pending_means.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        settle();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        apply_register(idx, data);
        reg_writes++;
    endtask

    task automatic send_pixel(logic [PIX_W-1:0] px, bit typed, logic [PIX_W-1:0] typed_mean);
        window_mean_t r;
        while (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= px;
        do
            @(posedge clk);
        while (!pix_if.ready);
        pixels_sent++;
        if (filter_pixel(px, r))
        begin
            if (typed)
                r.mean = typed_mean;
            pending_means.push_back(r);
        end
    endtask

    task automatic run_random_frame();
        fill_t            fill;
        logic [PIX_W-1:0] level;
        int unsigned      split;
        int unsigned      n;
        bit               mid;
        case ($urandom_range(7))
            0:       fill = FILL_CONST;
            1:       fill = FILL_EXTREME;
            2:       fill = FILL_RAMP;
            default: fill = FILL_RANDOM;
        endcase
        case ($urandom_range(2))
            0:       level = 8'h00;
            1:       level = 8'hFF;
            default: level = PIX_W'($urandom_range(255));
        endcase
        if ($urandom_range(1))
            write_reg(REG_IMAGE_WIDTH, pick_size(14));
        if ($urandom_range(1))
            write_reg(REG_IMAGE_HEIGHT, pick_size(10));
        if ($urandom_range(15) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, CFG_DATA_W'($urandom));
        mid   = ($urandom_range(3) == 0);
        split = $urandom_range(eff_width() * eff_height() - 1, 1);
        n     = 0;
        do
        begin
            send_pixel(pick_pixel(fill, level, n), 1'b0, '0);
            n++;
            // width only shrinks mid-frame, so every store entry read was written this frame
            if (mid && n == split)
            begin
                if ($urandom_range(1))
                    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(12, 7)));
                else
                    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(eff_width(), 7)));
            end
        end
        while (row_cnt != 0 || col_cnt != 0);
    endtask

    always @(posedge clk)
        res_if.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin : result_check
        window_mean_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_means.size() == 0)
            begin
                $display("%0t: unexpected result row %0d col %0d mean %0d last %0d", $time,
                         res_if.centre_row, res_if.centre_col, res_if.mean,
                         res_if.last_of_frame);
                mismatches++;
            end
            else
            begin
                want = pending_means.pop_front();
                check_field("centre_row", want.centre_row, res_if.centre_row);
                check_field("centre_col", want.centre_col, res_if.centre_col);
                check_field("mean", want.mean, res_if.mean);
                check_field("last_of_frame", want.last, res_if.last_of_frame);
                means_seen++;
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("box_mean_filter_7x7 test failed");
        $finish;
    end

    initial
    begin : stimulus
        int phase_end;
        rst_n        <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= REG_IMAGE_WIDTH;
        cfg_if.data  <= '0;
        pix_if.valid <= 1'b0;
        pix_if.pixel <= '0;
        gap_pct      = 0;
        stall_pct    = 0;
        mismatches   = 0;
        pixels_sent  = 0;
        means_seen   = 0;
        frames_done  = 0;
        reg_writes   = 0;
        width_reg    = WIDTH_RESET;
        height_reg   = HEIGHT_RESET;
        win_sum      = '0;
        row_cnt      = '0;
        col_cnt      = '0;
        foreach (col_win[k])
            col_win[k] = '0;
        foreach (line_mem[k])
            line_mem[k] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_frames[i])
        begin
            if (directed_frames[i].do_cfg)
                write_reg(directed_frames[i].idx, directed_frames[i].data);
            for (int n = 0; n < directed_frames[i].npix; n++)
                send_pixel(pick_pixel(directed_frames[i].fill, directed_frames[i].val, n),
                           directed_frames[i].typed, directed_frames[i].val);
        end

        // flow-control phases: free running, sender gaps, receiver stalls, both
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 50; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 50; end
                default: begin gap_pct = 25; stall_pct = 25; end
            endcase
            phase_end = pixels_sent + PHASE_ITEMS;
            while (pixels_sent < phase_end)
                run_random_frame();
        end

        pix_if.valid <= 1'b0;
        for (int t = 0; t < DRAIN_LIMIT && pending_means.size() != 0; t++)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
        if (pending_means.size() != 0)
        begin
            $display("%0t: %0d window means never arrived", $time, pending_means.size());
            mismatches += pending_means.size();
        end

        $display("Sent %0d pixels in %0d frames, checked %0d window means, %0d register writes",
                 pixels_sent, frames_done, means_seen, reg_writes);
        $display("512-wide default row, frames 7 to 20 wide, saturating and mid-frame resizes, %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("box_mean_filter_7x7 test passed");
        else
            $display("box_mean_filter_7x7 test failed");
        $finish;
    end

endmodule
